FILE: rtl/sycc_pkg.sv
// ----------------------------------------------------------------------------
// sycc_pkg
// Types and constants shared by the YCbCr to RGB upsampler and its channels.
// ----------------------------------------------------------------------------
package sycc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_SAMPLE_PRECISION = 3'd0,
    REG_SUBSAMPLE_MODE   = 3'd1,
    REG_ODD_FIRST_COLUMN = 3'd2,
    REG_ODD_FIRST_ROW    = 3'd3,
    REG_FRAME_WIDTH      = 3'd4,
    REG_FRAME_HEIGHT     = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_444 = 2'd0,
    MODE_422 = 2'd1,
    MODE_420 = 2'd2,
    MODE_ALT = 2'd3
  } subsample_mode_t;

  localparam int CFG_DATA_W   = 13;
  localparam int HEIGHT_LIMIT = 4096;

  // Q2.16 coefficients
  localparam logic signed [18:0] K_CR_R = 19'sd91881;
  localparam logic signed [18:0] K_CB_G = 19'sd22544;
  localparam logic signed [18:0] K_CR_G = 19'sd46793;
  localparam logic signed [18:0] K_CB_B = 19'sd116130;

  typedef struct packed {
    logic [15:0] luma;
    logic [15:0] blue_diff;
    logic [15:0] red_diff;
  } ycc_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_end;
  } rgb_item_t;

endpackage

FILE: rtl/sycc_stream_if.sv
// ----------------------------------------------------------------------------
// sycc_stream_if
// Valid/ready stream channel carrying one payload item per request.
// ----------------------------------------------------------------------------
interface sycc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/sycc_to_rgb_upsampler_unit.sv
// ----------------------------------------------------------------------------
// sycc_to_rgb_upsampler_unit
// YCbCr to RGB conversion with 4:2:2 / 4:2:0 chroma upsampling.
// ----------------------------------------------------------------------------
// Takes one luma request per clock in raster order and returns one clamped
// RGB pixel per request through the pipeline stages below; a full
// rate of one pixel per clock is held as long as the sink keeps ready high,
// and stalls collapse bubbles stage by stage. Chroma for the bottom row of
// a 4:2:0 pair comes from a single-port line memory (MAX_WIDTH/2 entries of
// Cb and Cr) that the top row writes and the bottom row reads through a
// registered read port; the memory needs no clearing pass after reset.
// Configuration writes are meant for idle time; writing frame_width or
// frame_height restarts the frame position at the top left corner.
// ----------------------------------------------------------------------------
module sycc_to_rgb_upsampler_unit #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_PRECISION = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [2:0]                      cfg_index,
  input  logic [sycc_pkg::CFG_DATA_W-1:0] cfg_data,
  sycc_stream_if.sink                     ycc,
  sycc_stream_if.source                   rgb
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // ---------------- configuration ----------------
  logic [4:0]  sample_precision;
  logic [1:0]  subsample_mode;
  logic        odd_first_column;
  logic        odd_first_row;
  logic [12:0] frame_width;
  logic [12:0] frame_height;
  logic        size_write;

  assign size_write = cfg_write &&
    (cfg_index == sycc_pkg::REG_FRAME_WIDTH || cfg_index == sycc_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_precision <= 5'd8;
      subsample_mode   <= sycc_pkg::MODE_444;
      odd_first_column <= 1'b0;
      odd_first_row    <= 1'b0;
      frame_width      <= 13'd640;
      frame_height     <= 13'd480;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sycc_pkg::REG_SAMPLE_PRECISION: sample_precision <= cfg_data[4:0];
        sycc_pkg::REG_SUBSAMPLE_MODE:   subsample_mode   <= cfg_data[1:0];
        sycc_pkg::REG_ODD_FIRST_COLUMN: odd_first_column <= cfg_data[0];
        sycc_pkg::REG_ODD_FIRST_ROW:    odd_first_row    <= cfg_data[0];
        sycc_pkg::REG_FRAME_WIDTH:      frame_width      <= cfg_data;
        sycc_pkg::REG_FRAME_HEIGHT:     frame_height     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective last column / row and precision
  logic [CW-1:0] last_col;
  logic [11:0]   last_row;
  logic [12:0]   width_m1;
  logic [12:0]   height_m1;
  logic [4:0]    prec;
  logic [16:0]   chroma_offset;
  logic [15:0]   ceiling;

  assign width_m1  = frame_width - 13'd1;
  assign height_m1 = frame_height - 13'd1;

  always_comb begin
    if (frame_width == 13'd0) begin
      last_col = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      last_col = CW'(MAX_WIDTH - 1);
    end else begin
      last_col = CW'(width_m1);
    end
    if (frame_height == 13'd0) begin
      last_row = '0;
    end else if (32'(frame_height) > 32'(sycc_pkg::HEIGHT_LIMIT)) begin
      last_row = 12'(sycc_pkg::HEIGHT_LIMIT - 1);
    end else begin
      last_row = height_m1[11:0];
    end
    if (sample_precision == 5'd0) begin
      prec = 5'd1;
    end else if (sample_precision > 5'(MAX_PRECISION)) begin
      prec = 5'(MAX_PRECISION);
    end else begin
      prec = sample_precision;
    end
  end

  assign chroma_offset = 17'd1 << (prec - 5'd1);
  assign ceiling       = 16'((17'd1 << prec) - 17'd1);

  // ---------------- pipeline control ----------------
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic accept;

  assign en4       = !v4 || rgb.ready;
  assign en3       = !v3 || en4;
  assign en2       = !v2 || en3;
  assign en1       = !v1 || en2;
  assign ycc.ready = en1;
  assign accept    = ycc.valid && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= ycc.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // ---------------- stage 0: position and chroma source ----------------
  logic [CW-1:0]   column_count;
  logic [11:0]     row_count;
  logic [15:0]     held_blue;
  logic [15:0]     held_red;
  logic [CW-1:0]   col_rel;
  logic [CW-1:0]   pair_idx;
  logic [CW-1:0]   pair_wrap;
  logic [AW-1:0]   idx;
  logic            vertical;
  logic            zero_row;
  logic            bottom;
  logic            new_chroma;
  logic            mem_we;
  logic            use_mem;
  logic [15:0]     cb0, cr0;
  logic            frame_end0;
  logic            col_last;

  assign vertical = subsample_mode[1];
  assign col_rel  = column_count - CW'(odd_first_column);
  assign pair_idx = col_rel >> 1;
  assign pair_wrap = (pair_idx >= CW'(DEPTH)) ? pair_idx - CW'(DEPTH) : pair_idx;
  assign idx       = pair_wrap[AW-1:0];
  assign zero_row  = vertical && odd_first_row && (row_count == 12'd0);
  assign bottom    = vertical && !zero_row && (row_count[0] ^ odd_first_row);
  assign col_last   = (column_count == last_col);
  assign frame_end0 = col_last && (row_count == last_row);

  always_comb begin
    new_chroma = 1'b0;
    mem_we     = 1'b0;
    use_mem    = 1'b0;
    cb0        = '0;
    cr0        = '0;
    if (subsample_mode == sycc_pkg::MODE_444) begin
      cb0 = ycc.payload.blue_diff;
      cr0 = ycc.payload.red_diff;
    end else if (odd_first_column && column_count == '0) begin
      cb0 = '0;
      cr0 = '0;
    end else if (zero_row) begin
      cb0 = '0;
      cr0 = '0;
    end else if (bottom) begin
      use_mem = 1'b1;
    end else begin
      new_chroma = !col_rel[0];
      mem_we     = new_chroma && vertical && accept;
      cb0        = new_chroma ? ycc.payload.blue_diff : held_blue;
      cr0        = new_chroma ? ycc.payload.red_diff : held_red;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      held_blue    <= '0;
      held_red     <= '0;
    end else if (size_write) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (new_chroma) begin
        held_blue <= ycc.payload.blue_diff;
        held_red  <= ycc.payload.red_diff;
      end
      if (col_last) begin
        column_count <= '0;
        row_count    <= (row_count == last_row) ? 12'd0 : row_count + 12'd1;
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Line memory: {Cb, Cr} per pixel pair. A write completes before the next
  // request can read, so no forwarding is needed.
  logic [31:0] line_store [DEPTH];
  logic [31:0] line_rd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_store[idx] <= {ycc.payload.blue_diff, ycc.payload.red_diff};
    end
    if (en1) begin
      line_rd <= line_store[idx];
    end
  end

  // ---------------- stage 1: chroma select, remove offset ----------------
  logic [15:0] y1, cb1, cr1;
  logic        use_mem1, fe1;
  logic [15:0] cb_sel, cr_sel;
  logic signed [17:0] cbd, crd;

  always_ff @(posedge clk) begin
    if (en1) begin
      y1       <= ycc.payload.luma;
      cb1      <= cb0;
      cr1      <= cr0;
      use_mem1 <= use_mem;
      fe1      <= frame_end0;
    end
  end

  assign cb_sel = use_mem1 ? line_rd[31:16] : cb1;
  assign cr_sel = use_mem1 ? line_rd[15:0]  : cr1;
  assign cbd    = $signed({2'b00, cb_sel}) - $signed({1'b0, chroma_offset});
  assign crd    = $signed({2'b00, cr_sel}) - $signed({1'b0, chroma_offset});

  // ---------------- stage 2: products ----------------
  logic [15:0]        y2;
  logic               fe2;
  logic signed [37:0] p_r, p_gb, p_gr, p_b;

  always_ff @(posedge clk) begin
    if (en2) begin
      y2   <= y1;
      fe2  <= fe1;
      p_r  <= crd * sycc_pkg::K_CR_R;
      p_gb <= cbd * sycc_pkg::K_CB_G;
      p_gr <= crd * sycc_pkg::K_CR_G;
      p_b  <= cbd * sycc_pkg::K_CB_B;
    end
  end

  // ---------------- stage 3: sum and truncate toward zero ----------------
  logic signed [38:0] p_g;
  logic signed [38:0] t_r, t_g, t_b;
  logic [15:0]        y3;
  logic               fe3;
  logic signed [19:0] tr_r, tr_g, tr_b;

  assign p_g = p_gb + p_gr;
  // bias negative products by 2^16-1 so the arithmetic shift rounds to zero
  assign t_r = p_r + (p_r[37] ? 39'sd65535 : 39'sd0);
  assign t_g = p_g + (p_g[38] ? 39'sd65535 : 39'sd0);
  assign t_b = p_b + (p_b[37] ? 39'sd65535 : 39'sd0);

  always_ff @(posedge clk) begin
    if (en3) begin
      y3   <= y2;
      fe3  <= fe2;
      tr_r <= t_r[35:16];
      tr_g <= t_g[35:16];
      tr_b <= t_b[35:16];
    end
  end

  // ---------------- stage 4: add luma, clamp, output register ----------------
  logic signed [20:0] r_sum, g_sum, b_sum;
  sycc_pkg::rgb_item_t out_item;

  function automatic logic [15:0] clamp(input logic signed [20:0] v,
                                        input logic [15:0] top);
    logic [15:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({5'b0, top})) begin
      res = top;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  assign r_sum = $signed({5'b0, y3}) + 21'(tr_r);
  assign g_sum = $signed({5'b0, y3}) - 21'(tr_g);
  assign b_sum = $signed({5'b0, y3}) + 21'(tr_b);

  always_ff @(posedge clk) begin
    if (en4) begin
      out_item.red       <= clamp(r_sum, ceiling);
      out_item.green     <= clamp(g_sum, ceiling);
      out_item.blue      <= clamp(b_sum, ceiling);
      out_item.frame_end <= fe3;
    end
  end

  assign rgb.valid   = v4;
  assign rgb.payload = out_item;

  // ---------------- assertions ----------------
  a_size_restart: assert property (@(posedge clk) disable iff (rst)
    size_write |=> (column_count == '0 && row_count == 12'd0))
    else $error("frame position not restarted after size write");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end0 && !size_write) |=> (column_count == '0 && row_count == 12'd0))
    else $error("frame position did not wrap after last pixel");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    (!$past(cfg_write)) |-> (column_count <= last_col))
    else $error("column counter beyond frame width");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(v4) |-> $past(v3))
    else $error("output valid without a pixel in the last stage");

endmodule

FILE: tb/sv/sycc_to_rgb_upsampler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sycc_to_rgb_upsampler_unit_tb
// Self-checking bench for the YCbCr to RGB upsampler. A cycle-free predictor
// tracks frame position, held chroma and the 4:2:0 line store, and every RGB
// pixel leaving the block is compared with the oldest predicted pixel.
// Directed colour and register extremes come first, then randomized frames in every
// subsampling mode under random stalls on both channels.
// ----------------------------------------------------------------------------
module sycc_to_rgb_upsampler_unit_tb;

  localparam int MAX_WIDTH     = 4096;
  localparam int MAX_PRECISION = 16;
  localparam int STORE_DEPTH   = MAX_WIDTH / 2;

  localparam longint CR_TO_R = 91881;
  localparam longint CB_TO_G = 22544;
  localparam longint CR_TO_G = 46793;
  localparam longint CB_TO_B = 116130;

  localparam int IDLE_NONE  = 0;
  localparam int IDLE_HEAVY = 73;
  localparam int IDLE_BOTH  = 38;

  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 60;
  localparam int STALL_LIMIT   = 2000;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [2:0]                      cfg_index;
  logic [sycc_pkg::CFG_DATA_W-1:0] cfg_data;

  sycc_stream_if #(.payload_t(sycc_pkg::ycc_item_t)) ycc_bus ();
  sycc_stream_if #(.payload_t(sycc_pkg::rgb_item_t)) rgb_bus ();

  sycc_to_rgb_upsampler_unit #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_PRECISION(MAX_PRECISION)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ycc      (ycc_bus),
    .rgb      (rgb_bus)
  );

  // predictor copy of registers and state
  logic [4:0]                cfg_precision;
  sycc_pkg::subsample_mode_t cfg_mode;
  logic                      cfg_odd_col;
  logic                      cfg_odd_row;
  logic [12:0]               cfg_width;
  logic [12:0]               cfg_height;
  logic [15:0]               held_cb;
  logic [15:0]               held_cr;
  logic [15:0]               line_cb [STORE_DEPTH];
  logic [15:0]               line_cr [STORE_DEPTH];
  int unsigned               col_pos;
  int unsigned               row_pos;

  sycc_pkg::rgb_item_t pending_rgb[$];
  int                  fail_count;
  int                  send_idle_pct;
  int                  sink_stall_pct;
  int                  hold_requests;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic longint q16_trunc(longint p);
    if (p < 0) return -((-p) >>> 16);
    return p >>> 16;
  endfunction

  function automatic logic [15:0] clamp_sample(longint v, longint top);
    if (v < 0) return 16'd0;
    if (v > top) return top[15:0];
    return v[15:0];
  endfunction

  function automatic int unsigned eff_precision();
    if (cfg_precision == 0) return 1;
    if (cfg_precision > MAX_PRECISION) return MAX_PRECISION;
    return cfg_precision;
  endfunction

  // converts one pixel and advances the frame position
  function automatic sycc_pkg::rgb_item_t convert_ycc(sycc_pkg::ycc_item_t px);
    int unsigned         prec, w, h, c, r, rel, idx;
    logic [15:0]         cb, cr;
    bit                  vert, zero_row, bottom;
    longint              offs, top, cbd, crd, rv, gv, bv;
    sycc_pkg::rgb_item_t res;
    prec = eff_precision();
    w = cfg_width;
    h = cfg_height;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > sycc_pkg::HEIGHT_LIMIT) h = sycc_pkg::HEIGHT_LIMIT;
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    if (r >= h) r = 0;
    cb = 16'd0;
    cr = 16'd0;
    if (cfg_mode == sycc_pkg::MODE_444) begin
      cb = px.blue_diff;
      cr = px.red_diff;
    end else if (!(cfg_odd_col && c == 0)) begin
      rel = c - cfg_odd_col;
      idx = (rel >> 1) % STORE_DEPTH;
      vert = (cfg_mode == sycc_pkg::MODE_420 || cfg_mode == sycc_pkg::MODE_ALT);
      zero_row = vert && cfg_odd_row && r == 0;
      bottom = vert && !zero_row && (((r - cfg_odd_row) & 1) != 0);
      if (bottom) begin
        cb = line_cb[idx];
        cr = line_cr[idx];
      end else if (!zero_row) begin
        if (rel[0] == 1'b0) begin
          held_cb = px.blue_diff;
          held_cr = px.red_diff;
          if (vert) begin
            line_cb[idx] = px.blue_diff;
            line_cr[idx] = px.red_diff;
          end
        end
        cb = held_cb;
        cr = held_cr;
      end
    end
    offs = longint'(1) << (prec - 1);
    top  = (longint'(1) << prec) - 1;
    cbd  = longint'(cb) - offs;
    crd  = longint'(cr) - offs;
    rv = longint'(px.luma) + q16_trunc(CR_TO_R * crd);
    gv = longint'(px.luma) - q16_trunc(CB_TO_G * cbd + CR_TO_G * crd);
    bv = longint'(px.luma) + q16_trunc(CB_TO_B * cbd);
    res.red       = clamp_sample(rv, top);
    res.green     = clamp_sample(gv, top);
    res.blue      = clamp_sample(bv, top);
    res.frame_end = (c == w - 1) && (r == h - 1);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
    return res;
  endfunction

  function automatic logic [15:0] random_sample();
    int unsigned p, pick;
    p = eff_precision();
    pick = $urandom_range(15);
    case (pick)
      0: return 16'($urandom);
      1: return 16'd0;
      2: return 16'((32'd1 << p) - 1);
      3: return 16'(32'd1 << (p - 1));
      default: return 16'($urandom & ((32'd1 << p) - 1));
    endcase
  endfunction

  function automatic sycc_pkg::ycc_item_t random_pixel();
    sycc_pkg::ycc_item_t px;
    px.luma      = random_sample();
    px.blue_diff = random_sample();
    px.red_diff  = random_sample();
    return px;
  endfunction

  // entered and left just after a falling edge
  task automatic push_pixel(input sycc_pkg::ycc_item_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      ycc_bus.valid <= 1'b0;
      @(negedge clk);
    end
    ycc_bus.valid   <= 1'b1;
    ycc_bus.payload <= px;
    @(posedge clk);
    while (!ycc_bus.ready) @(posedge clk);
    pending_rgb.push_back(convert_ycc(px));
    @(negedge clk);
  endtask

  // stop offering, let every predicted pixel come out, then let the pipe empty
  task automatic settle();
    ycc_bus.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input sycc_pkg::reg_index_t idx, input logic [12:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      sycc_pkg::REG_SAMPLE_PRECISION: cfg_precision = val[4:0];
      sycc_pkg::REG_SUBSAMPLE_MODE:   cfg_mode = sycc_pkg::subsample_mode_t'(val[1:0]);
      sycc_pkg::REG_ODD_FIRST_COLUMN: cfg_odd_col = val[0];
      sycc_pkg::REG_ODD_FIRST_ROW:    cfg_odd_row = val[0];
      sycc_pkg::REG_FRAME_WIDTH: begin
        cfg_width = val;
        col_pos = 0;
        row_pos = 0;
      end
      sycc_pkg::REG_FRAME_HEIGHT: begin
        cfg_height = val;
        col_pos = 0;
        row_pos = 0;
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  // size writes go last so every setup starts at the top left corner
  task automatic setup_frame(input int prec, mode, odd_col, odd_row, width, height);
    settle();
    write_reg(sycc_pkg::REG_SAMPLE_PRECISION, 13'(prec));
    write_reg(sycc_pkg::REG_SUBSAMPLE_MODE, 13'(mode));
    write_reg(sycc_pkg::REG_ODD_FIRST_COLUMN, 13'(odd_col));
    write_reg(sycc_pkg::REG_ODD_FIRST_ROW, 13'(odd_row));
    write_reg(sycc_pkg::REG_FRAME_WIDTH, 13'(width));
    write_reg(sycc_pkg::REG_FRAME_HEIGHT, 13'(height));
    cfg_write <= 1'b0;
  endtask

  task automatic run_random_frame(input int prec, mode, odd_col, odd_row, width, height,
                                  input int snd_pct, stall_pct, count);
    setup_frame(prec, mode, odd_col, odd_row, width, height);
    send_idle_pct  = snd_pct;
    sink_stall_pct = stall_pct;
    repeat (count) push_pixel(random_pixel());
  endtask

  // reset defaults: 8 bit, 4:4:4; out-of-range luma and chroma corners
  task automatic test_color_extremes();
    send_idle_pct  = IDLE_NONE;
    sink_stall_pct = IDLE_NONE;
    push_pixel('{luma: 16'd0,     blue_diff: 16'd0,     red_diff: 16'd0});
    push_pixel('{luma: 16'd255,   blue_diff: 16'd255,   red_diff: 16'd255});
    push_pixel('{luma: 16'd128,   blue_diff: 16'd128,   red_diff: 16'd128});
    push_pixel('{luma: 16'hFFFF,  blue_diff: 16'hFFFF,  red_diff: 16'hFFFF});
    push_pixel('{luma: 16'd0,     blue_diff: 16'd0,     red_diff: 16'hFFFF});
    push_pixel('{luma: 16'd255,   blue_diff: 16'hFFFF,  red_diff: 16'd0});
  endtask

  task automatic test_register_limits();
    // zero precision, unused mode, zero sizes
    setup_frame(0, sycc_pkg::MODE_ALT, 0, 0, 0, 0);
    push_pixel('{luma: 16'd1, blue_diff: 16'd0, red_diff: 16'd1});
    push_pixel('{luma: 16'd0, blue_diff: 16'd1, red_diff: 16'd0});
    push_pixel('{luma: 16'hFFFF, blue_diff: 16'hFFFF, red_diff: 16'hFFFF});
    // precision and sizes above range, odd first column in 4:2:2
    setup_frame(31, sycc_pkg::MODE_422, 1, 0, 8191, 8191);
    push_pixel('{luma: 16'h8000, blue_diff: 16'hFFFF, red_diff: 16'hFFFF});
    push_pixel('{luma: 16'h8000, blue_diff: 16'h0000, red_diff: 16'hFFFF});
    push_pixel('{luma: 16'h1234, blue_diff: 16'hFFFF, red_diff: 16'h0000});
    push_pixel('{luma: 16'hFFFF, blue_diff: 16'h8000, red_diff: 16'h8000});
    // 3x3 frame, 4:2:0, odd first row and column: zero row, top, bottom
    setup_frame(16, sycc_pkg::MODE_420, 1, 1, 3, 3);
    push_pixel('{luma: 16'h4000, blue_diff: 16'hFFFF, red_diff: 16'h0000});
    push_pixel('{luma: 16'h4000, blue_diff: 16'h0000, red_diff: 16'hFFFF});
    push_pixel('{luma: 16'hC000, blue_diff: 16'h1111, red_diff: 16'h2222});
    push_pixel('{luma: 16'h8000, blue_diff: 16'hFFFF, red_diff: 16'hFFFF});
    push_pixel('{luma: 16'h8000, blue_diff: 16'hF000, red_diff: 16'h0F00});
    push_pixel('{luma: 16'h8000, blue_diff: 16'h3333, red_diff: 16'h4444});
    push_pixel('{luma: 16'h7FFF, blue_diff: 16'hAAAA, red_diff: 16'h5555});
    push_pixel('{luma: 16'h7FFF, blue_diff: 16'h5555, red_diff: 16'hAAAA});
    push_pixel('{luma: 16'h0001, blue_diff: 16'h0000, red_diff: 16'h0000});
  endtask

  task automatic test_subsample_modes();
    run_random_frame(8,  sycc_pkg::MODE_444, 0, 0, 5, 4, IDLE_NONE,  IDLE_NONE,  80);
    run_random_frame(8,  sycc_pkg::MODE_422, 0, 0, 6, 3, IDLE_HEAVY, IDLE_NONE,  100);
    run_random_frame(10, sycc_pkg::MODE_422, 1, 0, 7, 2, IDLE_NONE,  IDLE_HEAVY, 100);
    run_random_frame(8,  sycc_pkg::MODE_420, 0, 0, 8, 5, IDLE_BOTH,  IDLE_BOTH,  120);
    run_random_frame(12, sycc_pkg::MODE_420, 1, 1, 9, 6, IDLE_NONE,  IDLE_NONE,  120);
    run_random_frame(16, sycc_pkg::MODE_420, 0, 1, 4, 7, IDLE_HEAVY, IDLE_NONE,  100);
    run_random_frame(1,  sycc_pkg::MODE_420, 1, 0, 3, 3, IDLE_NONE,  IDLE_HEAVY, 80);
  endtask

  task automatic test_random_settings();
    int idle_pick;
    repeat (5) begin
      idle_pick = $urandom_range(3);
      run_random_frame($urandom_range(20), $urandom_range(3), $urandom_range(1),
                       $urandom_range(1), $urandom_range(1, 12), $urandom_range(1, 6),
                       (idle_pick == 1) ? IDLE_HEAVY : (idle_pick == 3) ? IDLE_BOTH : IDLE_NONE,
                       (idle_pick == 2) ? IDLE_HEAVY : (idle_pick == 3) ? IDLE_BOTH : IDLE_NONE,
                       40);
    end
  endtask

  task automatic test_largest_frame();
    run_random_frame(8, sycc_pkg::MODE_420, 1, 0, 4096, 4096, IDLE_BOTH, IDLE_BOTH, 40);
  endtask

  // sink holds off long enough to back the block up into the sender
  task automatic test_backpressure();
    setup_frame(8, sycc_pkg::MODE_420, 0, 0, 6, 4);
    send_idle_pct  = IDLE_NONE;
    sink_stall_pct = IDLE_NONE;
    hold_requests++;
    repeat (100) push_pixel(random_pixel());
    settle();
    repeat (30) push_pixel(random_pixel());
  endtask

  // sink side: random stalls plus an occasional long hold
  initial begin : sink_side
    int unsigned hold_left;
    int          hold_served;
    hold_left   = 0;
    hold_served = 0;
    rgb_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        rgb_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        rgb_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sycc_pkg::rgb_item_t got, want;
    if (!rst && rgb_bus.valid && rgb_bus.ready) begin
      got = rgb_bus.payload;
      if (pending_rgb.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d frame_end %0d",
               got.red, got.green, got.blue, got.frame_end);
        fail_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, got.red);
          fail_count++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, got.green);
          fail_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, got.blue);
          fail_count++;
        end
        if (got.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, got.frame_end);
          fail_count++;
        end
      end
    end
  end

  // no request moving on either channel for too long
  always @(posedge clk) begin
    int quiet_cycles;
    if (rst || (ycc_bus.valid && ycc_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $error("no request moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = sycc_pkg::REG_SAMPLE_PRECISION;
    cfg_data        = '0;
    ycc_bus.valid   = 1'b0;
    ycc_bus.payload = '0;
    cfg_precision   = 5'd8;
    cfg_mode        = sycc_pkg::MODE_444;
    cfg_odd_col     = 1'b0;
    cfg_odd_row     = 1'b0;
    cfg_width       = 13'd640;
    cfg_height      = 13'd480;
    held_cb         = 16'd0;
    held_cr         = 16'd0;
    col_pos         = 0;
    row_pos         = 0;
    fail_count      = 0;
    send_idle_pct   = IDLE_NONE;
    sink_stall_pct  = IDLE_NONE;
    hold_requests   = 0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      line_cb[i] = 16'd0;
      line_cr[i] = 16'd0;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    test_color_extremes();
    test_register_limits();
    test_subsample_modes();
    test_random_settings();
    test_largest_frame();
    test_backpressure();

    settle();
    if (pending_rgb.size() != 0) begin
      $error("%0d predicted pixels never came out", pending_rgb.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
